/* sv/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk while rst_n is high
`define OAHT_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// next-cycle implication, checked on clk while rst_n is high
`define OAHT_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

/* sv/oaht_pkg.sv */
// types and constants shared by the hash table controller and datapath
`timescale 1ns / 1ps

package oaht_pkg;

    localparam int KEY_W   = 64;
    localparam int HASH_W  = 32;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 9;
    localparam int MAXC_W  = 8;

    localparam logic [MAXC_W-1:0] MAX_COUNT_RESET = 8'd192;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_SET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_TOMB  = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_CHECK
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] new_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] value_out;
        logic               status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic home;
        logic probe;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic home_valid;
        logic probe_end;
    } sts_t;

endpackage

/* sv/open_addressing_hash_table.sv */
// top level of the open addressing hash table with linear probing and tombstones
//
//   channel    ports                          handshake
//   ---------  -----------------------------  ------------------------------------
//   request    start, busy, request           taken at an edge with start & !busy
//   result     result_valid, result           one cycle strobe, cannot be held off
//   config     cfg_write, cfg_data            max_count written when cfg_write high
//
// after reset the slot state memory is cleared one entry a cycle, from slot 0 up to
// slot CAPACITY-1, with busy high; the config register can still be written then
// after the accepting edge the home slot state comes, then the probe state once per
// slot probed (one slot read per cycle through the registered memory read port),
// then the registered result strobe, shown in the first idle cycle, in which a new
// request can already be taken; for a CAPACITY that is not a power of two the home
// slot reduction (reciprocal multiply, then one correction) lengthens the home state
// the result side has no stall: each result is on the ports for one cycle only
`timescale 1ns / 1ps
`include "assert_macros.svh"

module open_addressing_hash_table #(
    parameter int CAPACITY = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        start,
    output logic                        busy,
    input  oaht_pkg::req_t              request,
    // result channel
    output logic                        result_valid,
    output oaht_pkg::rsp_t              result,
    // max_count register
    input  logic                        cfg_write,
    input  logic [oaht_pkg::MAXC_W-1:0] cfg_data
);

    // command and status between the controller and the datapath
    oaht_pkg::cmd_t cmd;
    oaht_pkg::sts_t sts;

    // state machine: clear pass, idle, home slot, probe loop
    oaht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // slot memories, probe logic, used count and result register
    oaht_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .request      (request),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // the result strobe only comes once the controller is back in idle
    `OAHT_ASSERT_NOW(a_result_when_idle, result_valid, !busy, "result while busy")
    // an accepted request makes the block busy in the next cycle
    `OAHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")
    // no result strobe right after an accept: the home slot and probe states come first
    `OAHT_ASSERT_NEXT(a_accept_no_result, start && !busy, !result_valid,
        "result too early after accept")
    // a refused set never reports a hit
    `OAHT_ASSERT_NOW(a_full_no_hit, result_valid && result.status, !result.hit,
        "table full with hit")
    // a nonzero value only comes with a get hit
    `OAHT_ASSERT_NOW(a_value_needs_hit, result_valid && (result.value_out != '0),
        result.hit, "value without hit")

endmodule

/* sv/oaht_ctrl.sv */
// control state machine for the hash table: clear pass, home slot, probe loop
`timescale 1ns / 1ps

module oaht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  oaht_pkg::sts_t sts,
    output oaht_pkg::cmd_t cmd
);

    oaht_pkg::fsm_state_t state_reg;
    oaht_pkg::fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oaht_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            oaht_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = oaht_pkg::ST_IDLE;
                end
            end
            oaht_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = oaht_pkg::ST_HOME;
                end
            end
            oaht_pkg::ST_HOME:
            begin
                cmd.home = 1'b1;
                if (sts.home_valid)
                begin
                    state_next = oaht_pkg::ST_CHECK;
                end
            end
            oaht_pkg::ST_CHECK:
            begin
                cmd.probe = 1'b1;
                if (sts.probe_end)
                begin
                    state_next = oaht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oaht_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

/* sv/oaht_datapath.sv */
// hash table datapath: slot memories, home slot reduction, probe and update logic
`timescale 1ns / 1ps

module oaht_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  oaht_pkg::cmd_t              cmd,
    output oaht_pkg::sts_t              sts,
    input  oaht_pkg::req_t              request,
    input  logic                        cfg_write,
    input  logic [oaht_pkg::MAXC_W-1:0] cfg_data,
    output logic                        result_valid,
    output oaht_pkg::rsp_t              result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

    // slot memories
    oaht_pkg::slot_state_t              state_mem [CAPACITY];
    logic [oaht_pkg::KEY_W-1:0]         key_mem   [CAPACITY];
    logic [oaht_pkg::VALUE_W-1:0]       value_mem [CAPACITY];

    oaht_pkg::slot_state_t              rd_state_reg;
    logic [oaht_pkg::KEY_W-1:0]         rd_key_reg;
    logic [oaht_pkg::VALUE_W-1:0]       rd_value_reg;

    oaht_pkg::req_t                     req_reg;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [IDX_W-1:0]                   probe_cnt_reg, probe_cnt_next;
    logic                               tomb_seen_reg, tomb_seen_next;
    logic [IDX_W-1:0]                   tomb_idx_reg, tomb_idx_next;
    logic [IDX_W-1:0]                   clear_cnt_reg, clear_cnt_next;
    logic [oaht_pkg::COUNT_W-1:0]       used_reg, used_next;
    logic [oaht_pkg::MAXC_W-1:0]        max_reg, max_next;
    oaht_pkg::rsp_t                     rsp_reg, rsp_next;
    logic                               rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]                   home_idx;
    logic                               home_valid;
    logic [IDX_W-1:0]                   idx_inc;
    logic [IDX_W-1:0]                   rd_addr;
    logic [IDX_W-1:0]                   wr_addr;
    logic                               we_state, we_key, we_value;
    oaht_pkg::slot_state_t              wr_state;

    logic                               match, empty, tomb, last;
    logic                               probe_end, have_slot, is_empty, full;
    logic [IDX_W-1:0]                   first_tomb, target;

    // home slot: hash modulo capacity
    generate
        if (POW2)
        begin : g_home_mask
            assign home_idx   = req_reg.key_hash[IDX_W-1:0];
            assign home_valid = 1'b1;
        end
        else
        begin : g_home_recip
            // reciprocal multiply gives a quotient short by at most one,
            // so the low remainder bits need one compare and subtract
            localparam logic [oaht_pkg::HASH_W-1:0] RECIP =
                oaht_pkg::HASH_W'((64'd1 << oaht_pkg::HASH_W) / CAPACITY);
            localparam logic [IDX_W:0] CAP_EXT    = (IDX_W + 1)'(CAPACITY);
            localparam logic [1:0]     HOME_STEPS = 2'd2;

            logic [1:0]                      step_reg, step_next;
            logic [2*oaht_pkg::HASH_W-1:0]   prod_reg, prod_next;
            logic [IDX_W:0]                  rem_reg, rem_next;
            logic [IDX_W:0]                  qc_low;

            assign prod_next = (2*oaht_pkg::HASH_W)'(req_reg.key_hash) *
                               (2*oaht_pkg::HASH_W)'(RECIP);
            assign qc_low    = prod_reg[oaht_pkg::HASH_W +: IDX_W + 1] * CAP_EXT;
            assign rem_next  = req_reg.key_hash[IDX_W:0] - qc_low;

            always_comb
            begin
                step_next = step_reg;
                if (cmd.accept)
                begin
                    step_next = '0;
                end
                else if (cmd.home && (step_reg != HOME_STEPS))
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= '0;
                end
                else
                begin
                    step_reg <= step_next;
                end
            end

            always_ff @(posedge clk)
            begin
                prod_reg <= prod_next;
                rem_reg  <= rem_next;
            end

            assign home_idx   = (rem_reg >= CAP_EXT) ? IDX_W'(rem_reg - CAP_EXT)
                                                     : rem_reg[IDX_W-1:0];
            assign home_valid = (step_reg == HOME_STEPS);
        end
    endgenerate

    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign rd_addr = cmd.home ? home_idx : idx_inc;

    // classify the slot just read
    assign match      = (rd_state_reg == oaht_pkg::SLOT_USED) && (rd_key_reg == req_reg.key);
    assign empty      = (rd_state_reg == oaht_pkg::SLOT_EMPTY);
    assign tomb       = (rd_state_reg == oaht_pkg::SLOT_TOMB);
    assign last       = (probe_cnt_reg == LAST_IDX);
    assign probe_end  = match || empty || last;
    assign first_tomb = tomb_seen_reg ? tomb_idx_reg : idx_reg;
    assign have_slot  = match || empty || tomb_seen_reg || tomb;
    assign is_empty   = empty && !tomb_seen_reg;
    assign target     = (match || is_empty) ? idx_reg : first_tomb;
    assign full       = !have_slot ||
                        (is_empty && ((used_reg + 1'b1) > {1'b0, max_reg}));

    always_comb
    begin
        we_state       = 1'b0;
        we_key         = 1'b0;
        we_value       = 1'b0;
        wr_state       = oaht_pkg::SLOT_EMPTY;
        wr_addr        = target;
        used_next      = used_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = 1'b0;
        clear_cnt_next = clear_cnt_reg;
        max_next       = cfg_write ? cfg_data : max_reg;

        if (cmd.clear)
        begin
            wr_addr        = clear_cnt_reg;
            we_state       = 1'b1;
            clear_cnt_next = clear_cnt_reg + 1'b1;
        end
        else if (cmd.probe && probe_end)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            case (oaht_pkg::op_t'(req_reg.opcode))
                oaht_pkg::OP_GET:
                begin
                    rsp_next.hit = match;
                    if (match)
                    begin
                        rsp_next.value_out = rd_value_reg;
                    end
                end
                oaht_pkg::OP_SET:
                begin
                    if (match)
                    begin
                        we_value = 1'b1;
                    end
                    else if (full)
                    begin
                        rsp_next.status = 1'b1;
                    end
                    else
                    begin
                        we_state     = 1'b1;
                        we_key       = 1'b1;
                        we_value     = 1'b1;
                        wr_state     = oaht_pkg::SLOT_USED;
                        rsp_next.hit = 1'b1;
                        if (is_empty)
                        begin
                            used_next = used_reg + 1'b1;
                        end
                    end
                end
                oaht_pkg::OP_DEL:
                begin
                    if (match)
                    begin
                        we_state     = 1'b1;
                        wr_state     = oaht_pkg::SLOT_TOMB;
                        rsp_next.hit = 1'b1;
                    end
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    // probe position and first tombstone
    always_comb
    begin
        idx_next       = idx_reg;
        probe_cnt_next = probe_cnt_reg;
        tomb_seen_next = tomb_seen_reg;
        tomb_idx_next  = tomb_idx_reg;
        if (cmd.home)
        begin
            idx_next       = home_idx;
            probe_cnt_next = '0;
            tomb_seen_next = 1'b0;
        end
        else if (cmd.probe)
        begin
            probe_cnt_next = probe_cnt_reg + 1'b1;
            if (!probe_end)
            begin
                idx_next = idx_inc;
            end
            if (tomb && !tomb_seen_reg)
            begin
                tomb_seen_next = 1'b1;
                tomb_idx_next  = idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            used_reg      <= '0;
            max_reg       <= oaht_pkg::MAX_COUNT_RESET;
            rsp_valid_reg <= 1'b0;
            tomb_seen_reg <= 1'b0;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            used_reg      <= used_next;
            max_reg       <= max_next;
            rsp_valid_reg <= rsp_valid_next;
            tomb_seen_reg <= tomb_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        idx_reg       <= idx_next;
        probe_cnt_reg <= probe_cnt_next;
        tomb_idx_reg  <= tomb_idx_next;
        rsp_reg       <= rsp_next;
    end

    // memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we_state)
        begin
            state_mem[wr_addr] <= wr_state;
        end
        if (we_key)
        begin
            key_mem[wr_addr] <= req_reg.key;
        end
        if (we_value)
        begin
            value_mem[wr_addr] <= req_reg.new_value;
        end
        rd_state_reg <= state_mem[rd_addr];
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    assign sts.clear_last = (clear_cnt_reg == LAST_IDX);
    assign sts.home_valid = home_valid;
    assign sts.probe_end  = probe_end;

    assign result_valid = rsp_valid_reg;
    assign result       = rsp_reg;

endmodule

/* bench/oaht_shadow_pkg.sv */
// shadow copy of the hash table that predicts and checks each result
`timescale 1ns / 1ps

package oaht_shadow_pkg;

    import oaht_pkg::*;

    localparam int unsigned SLOTS = 256;

    class shadow_table;
        slot_state_t        slot_st [SLOTS];
        logic [KEY_W-1:0]   slot_k  [SLOTS];
        logic [VALUE_W-1:0] slot_v  [SLOTS];
        int unsigned        fill_count;
        int unsigned        fill_limit;
        rsp_t               awaited_results [$];
        int unsigned        mismatches;
        int unsigned        requests_seen;
        int unsigned        results_seen;
        int unsigned        hits_seen;
        int unsigned        refusals_seen;

        function new();
            foreach (slot_st[i])
            begin
                slot_st[i] = SLOT_EMPTY;
                slot_k[i]  = '0;
                slot_v[i]  = '0;
            end
            fill_count    = 0;
            fill_limit    = MAX_COUNT_RESET;
            mismatches    = 0;
            requests_seen = 0;
            results_seen  = 0;
            hits_seen     = 0;
            refusals_seen = 0;
        endfunction

        function void set_fill_limit(logic [MAXC_W-1:0] limit);
            fill_limit = limit;
        endfunction

        // linear probe from the home slot, then apply the request
        function void apply_request(req_t r);
            rsp_t        want;
            bit          found;
            bit          have_slot;
            bit          is_empty;
            bit          tomb_seen;
            int unsigned pos;
            int unsigned tomb_pos;
            int unsigned slot;
            int unsigned n;
            want      = '0;
            found     = 1'b0;
            have_slot = 1'b0;
            is_empty  = 1'b0;
            tomb_seen = 1'b0;
            tomb_pos  = 0;
            slot      = 0;
            if (r.opcode != OP_NOP)
            begin
                pos = r.key_hash % SLOTS;
                for (n = 0; n < SLOTS && !have_slot; n++)
                begin
                    if (slot_st[pos] == SLOT_USED)
                    begin
                        if (slot_k[pos] == r.key)
                        begin
                            found     = 1'b1;
                            have_slot = 1'b1;
                            slot      = pos;
                        end
                    end
                    else if (slot_st[pos] == SLOT_TOMB)
                    begin
                        if (!tomb_seen)
                        begin
                            tomb_seen = 1'b1;
                            tomb_pos  = pos;
                        end
                    end
                    else
                    begin
                        have_slot = 1'b1;
                        if (tomb_seen)
                            slot = tomb_pos;
                        else
                        begin
                            slot     = pos;
                            is_empty = 1'b1;
                        end
                    end
                    pos = (pos + 1) % SLOTS;
                end
                if (!have_slot && tomb_seen)
                begin
                    have_slot = 1'b1;
                    slot      = tomb_pos;
                end
            end
            case (r.opcode)
                OP_GET:
                    if (found)
                    begin
                        want.hit       = 1'b1;
                        want.value_out = slot_v[slot];
                    end
                OP_SET:
                    if (found)
                        slot_v[slot] = r.new_value;
                    else if (!have_slot || (is_empty && fill_count + 1 > fill_limit))
                        want.status = 1'b1;
                    else
                    begin
                        if (is_empty)
                            fill_count++;
                        slot_st[slot] = SLOT_USED;
                        slot_k[slot]  = r.key;
                        slot_v[slot]  = r.new_value;
                        want.hit      = 1'b1;
                    end
                OP_DEL:
                    if (found)
                    begin
                        slot_st[slot] = SLOT_TOMB;
                        want.hit      = 1'b1;
                    end
                default: ;
            endcase
            requests_seen++;
            awaited_results.push_back(want);
        endfunction

        function void compare_result(rsp_t got);
            rsp_t want;
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request waiting, actual %h", $time, got);
                return;
            end
            want = awaited_results.pop_front();
            if (got.hit)
                hits_seen++;
            if (got.status)
                refusals_seen++;
            if (got.hit !== want.hit)
            begin
                mismatches++;
                $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            end
            if (got.value_out !== want.value_out)
            begin
                mismatches++;
                $display("%0t: value_out expected %h actual %h", $time,
                         want.value_out, got.value_out);
            end
            if (got.status !== want.status)
            begin
                mismatches++;
                $display("%0t: status expected %0b actual %0b", $time,
                         want.status, got.status);
            end
        endfunction
    endclass

endpackage

/* bench/tb.sv */
// testbench top for the open addressing hash table: directed and random requests
`timescale 1ns / 1ps

module tb;

    import oaht_pkg::*;
    import oaht_shadow_pkg::*;

    // quiet cycles allowed: clearing pass, a full 256 slot probe, gaps, all with margin
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    // the longest request probes all 256 slots
    localparam int unsigned TAIL_CYCLES    = 280;
    localparam int unsigned POOL_KEYS      = 320;
    localparam int unsigned PHASES         = 7;
    localparam int unsigned PHASE_ITEMS    = 218;

    localparam logic [KEY_W-1:0] KEY_A = 64'h0123_4567_89ab_cdef;
    localparam logic [KEY_W-1:0] KEY_B = 64'hfedc_ba98_7654_3210;
    localparam logic [KEY_W-1:0] KEY_C = 64'h5a5a_a5a5_0f0f_f0f0;
    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    req_t                request   = '0;
    logic                result_valid;
    rsp_t                result;
    logic                cfg_write = 1'b0;
    logic [MAXC_W-1:0]   cfg_data  = '0;

    shadow_table         sb;
    logic [KEY_W-1:0]    pool_key  [POOL_KEYS];
    logic [HASH_W-1:0]   pool_hash [POOL_KEYS];
    bit                  no_gap    = 1'b0;
    int unsigned         quiet_cycles = 0;

    // fill limits per random phase, low extremes first so the count has room to grow
    logic [MAXC_W-1:0]   phase_limit [PHASES] = '{8'd16, 8'd1, 8'd64, 8'd0,
                                                  8'd128, 8'd192, 8'd255};
    // keys in play per phase; the last phase brings enough keys to fill the table
    int unsigned         phase_pool  [PHASES] = '{24, 24, 60, 60, 120, 200, 320};

    open_addressing_hash_table #(
        .CAPACITY(256)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result monitor and watchdog; values read here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.compare_result(result);
            // any request taken or result seen counts as progress
            if ((start && !busy) || result_valid)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results still awaited", $time,
                         sb.awaited_results.size());
                $display("tb: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic req_t make_req(op_t op, logic [KEY_W-1:0] k,
                                      logic [HASH_W-1:0] h, logic [VALUE_W-1:0] v);
        req_t r;
        r.opcode    = op;
        r.key       = k;
        r.key_hash  = h;
        r.new_value = v;
        return r;
    endfunction

    // mostly well formed requests on pool keys with their own hash, plus some noise
    function automatic req_t random_request(int unsigned pool_size);
        req_t        r;
        int unsigned pick;
        int unsigned roll;
        pick        = $urandom_range(0, pool_size - 1);
        roll        = $urandom_range(0, 99);
        r.key       = pool_key[pick];
        r.key_hash  = pool_hash[pick];
        r.new_value = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0)
            r.new_value = $urandom_range(0, 1) ? ALL_ONES : '0;
        if (roll < 38)
            r.opcode = OP_GET;
        else if (roll < 76)
            r.opcode = OP_SET;
        else if (roll < 90)
            r.opcode = OP_DEL;
        else if (roll < 94)
        begin
            // no-op with junk fields
            r.opcode   = OP_NOP;
            r.key      = {$urandom, $urandom};
            r.key_hash = $urandom;
        end
        else if (roll < 97)
        begin
            // unknown key, random hash
            r.opcode   = 2'($urandom_range(0, 2));
            r.key      = {$urandom, $urandom};
            r.key_hash = $urandom;
        end
        else
        begin
            // known key with a stale home slot
            r.opcode        = 2'($urandom_range(0, 2));
            r.key_hash[7:0] = r.key_hash[7:0] + 8'($urandom_range(1, 255));
        end
        return r;
    endfunction

    // hold start until the request is taken, then note it in the shadow table
    task automatic send_request(req_t r);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.apply_request(r);
    endtask

    // stop sending and let every awaited result come back
    task automatic wait_for_results();
        start <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_fill_limit(logic [MAXC_W-1:0] limit);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_fill_limit(limit);
    endtask

    initial
    begin
        sb = new();
        // keys hash into eight clusters, one of them across the wrap at slot 255
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            pool_key[i]  = {$urandom, $urandom};
            pool_hash[i] = {24'($urandom), 8'((i % 8) * 32 + 28 + $urandom_range(0, 6))};
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // register written while the slot clearing pass still runs
        write_fill_limit(8'd0);

        // empty table, every set refused by a zero limit
        send_request(make_req(OP_GET, ALL_ONES, 32'h0000_0000, '0));
        send_request(make_req(OP_SET, KEY_A, 32'hffff_ffff, ALL_ONES));
        send_request(make_req(OP_DEL, KEY_A, 32'hffff_ffff, '0));
        send_request(make_req(op_t'(OP_NOP), ALL_ONES, 32'hffff_ffff, ALL_ONES));
        wait_for_results();

        write_fill_limit(8'd2);
        send_request(make_req(OP_SET, KEY_A, 32'hffff_ffff, ALL_ONES));
        // same home slot 255, lands in slot 0 after the wrap
        send_request(make_req(OP_SET, KEY_B, 32'h0000_00ff, '0));
        // count at limit, new key refused
        send_request(make_req(OP_SET, KEY_C, 32'h1234_56ff, 64'h1));
        // update of an existing key is never refused
        send_request(make_req(OP_SET, KEY_A, 32'hffff_ffff, 64'h5555_5555_5555_5555));
        send_request(make_req(OP_GET, KEY_A, 32'hffff_ffff, '0));
        send_request(make_req(OP_GET, KEY_B, 32'h0000_00ff, '0));
        send_request(make_req(OP_DEL, KEY_A, 32'hffff_ffff, '0));
        send_request(make_req(OP_GET, KEY_A, 32'hffff_ffff, '0));
        // lookup walks past the tombstone
        send_request(make_req(OP_GET, KEY_B, 32'h0000_00ff, '0));
        // tombstone reuse does not raise the count, so it is taken at the limit
        send_request(make_req(OP_SET, KEY_C, 32'h1234_56ff, 64'haaaa_aaaa_aaaa_aaaa));
        send_request(make_req(OP_GET, KEY_C, 32'h1234_56ff, '0));
        send_request(make_req(OP_DEL, KEY_B, 32'h0000_00ff, '0));
        send_request(make_req(OP_SET, KEY_B, 32'h0000_0000, 64'h0f0f_0f0f_0f0f_0f0f));
        wait_for_results();

        write_fill_limit(8'd255);
        // key zero is an ordinary key
        send_request(make_req(OP_SET, '0, 32'h8000_0000, ALL_ONES));
        send_request(make_req(OP_GET, '0, 32'h8000_0000, '0));
        send_request(make_req(OP_DEL, '0, 32'h8000_0000, '0));
        send_request(make_req(OP_DEL, '0, 32'h8000_0000, '0));
        send_request(make_req(OP_GET, ALL_ONES, 32'hffff_ffff, '0));
        send_request(make_req(op_t'(OP_NOP), {$urandom, $urandom}, $urandom, '0));

        // random phases, one fill limit each, written with the table idle
        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_results();
            write_fill_limit(phase_limit[p]);
            if (p == 5)
                write_fill_limit(MAX_COUNT_RESET);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // switch between back to back bursts and random gaps
                if ($urandom_range(0, 39) == 0)
                    no_gap = !no_gap;
                // now and then wait until every awaited result is back
                if ($urandom_range(0, 49) == 0)
                    wait_for_results();
                send_request(random_request(phase_pool[p]));
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d results, %0d hits, %0d refused sets",
                 sb.requests_seen, sb.results_seen, sb.hits_seen, sb.refusals_seen);
        $display("summary: fill limits from 0 to 255, final used count %0d, %0d mismatches",
                 sb.fill_count, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/oaht_pkg.sv
sv/oaht_ctrl.sv
sv/oaht_datapath.sv
sv/open_addressing_hash_table.sv
bench/oaht_shadow_pkg.sv
bench/tb.sv
